// File: rtl/sts_pkg.sv
package sts_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int TIME_BITS_DEF  = 32;

   // field widths on the ports
   localparam int ID_W       = 3;
   localparam int VAL_W      = 32;
   localparam int REQ_DATA_W = 72;   // 3 + 32 + 32 + 1 = 68, padded to bytes
   localparam int RSP_DATA_W = 40;   // 3 + 32 = 35, padded to bytes

   typedef enum logic [1:0] {
      MODE_ADVANCE = 2'd0,
      MODE_SCAN    = 2'd1,
      MODE_ARM     = 2'd2,
      MODE_CANCEL  = 2'd3
   } mode_type;

   localparam logic KIND_EXPIRE = 1'b0;
   localparam logic KIND_CANCEL = 1'b1;

endpackage

// File: rtl/sts_ram.sv
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/soft_timer_scan_engine.sv
// Channel  Dir  Ports                         Contents
// req      in   req_tvalid/tready/tdata/tuser  one request: advance, scan, arm, cancel
// rsp      out  rsp_tvalid/tready/tdata/tuser  one timer event of a scan
//                 /tlast                       (tlast marks the final event)
//
// Advance, arm and cancel are done in the idle state. A scan that runs
// walks every slot through the deadline/interval RAMs (one slot per cycle),
// then hands out its events, one slot visited per cycle while rsp is
// not stalled.
// req_tready is high only while no scan is walking or emitting; events wait in an output register.
// Synchronous reset clears time, cached deadline and all timer flags.
module soft_timer_scan_engine import sts_pkg::*; #(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] timer_id, [34:3] amount, [66:35] period, [67] repeat_req, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] event_timer, [34:3] next_deadline, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] event_kind
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_EMIT} state_type;

   state_type                state_ff, state_in;
   logic [TIME_BITS-1:0]     time_ff, time_in;
   logic [TIME_BITS-1:0]     soonest_ff, soonest_in;
   logic [NUM_TIMERS-1:0]    active_ff, active_in;
   logic [NUM_TIMERS-1:0]    periodic_ff, periodic_in;
   logic [NUM_TIMERS-1:0]    cancel_ff, cancel_in;
   logic [NUM_TIMERS-1:0]    ev_ff, ev_in;
   logic [NUM_TIMERS-1:0]    kind_ff, kind_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     any_exp_ff, any_exp_in;
   logic [TIME_BITS-1:0]     fold0_ff, fold0_in;
   logic [TIME_BITS-1:0]     folds_ff, folds_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic                     rsp_last_ff, rsp_last_in;

   // request fields
   mode_type                 req_mode;
   logic [ID_W-1:0]          req_timer_id;
   logic [VAL_W-1:0]         req_amount;
   logic [VAL_W-1:0]         req_period;
   logic                     req_repeat;

   logic                     req_fire;
   logic                     id_ok;
   logic                     scan_go;
   logic                     out_free;
   logic [NUM_TIMERS-1:0]    cur_bit;
   logic [IDX_W-1:0]         idx_next;

   // RAM ports
   logic                     dl_we, iv_we;
   logic [IDX_W-1:0]         dl_wa, iv_wa, rd_addr;
   logic [TIME_BITS-1:0]     dl_wd, iv_wd, dl_rd, iv_rd;

   // walk datapath
   logic                     fin_act;
   logic [TIME_BITS-1:0]     fin_dl;
   logic [TIME_BITS-1:0]     reload;
   logic                     exp_hit;

   assign req_mode     = mode_type'(req_tuser);
   assign req_timer_id = req_tdata[2:0];
   assign req_amount   = req_tdata[34:3];
   assign req_period   = req_tdata[66:35];
   assign req_repeat   = req_tdata[67];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign id_ok      = (6'(req_timer_id) < 6'(NUM_TIMERS));
   assign scan_go    = (active_ff != '0) &&
                       ((soonest_ff == '0) || (time_ff >= soonest_ff));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : IDX_W'(idx_ff + 1'b1);
   assign reload     = time_ff + iv_rd;

   always_comb begin
      cur_bit         = '0;
      cur_bit[idx_ff] = 1'b1;
   end

   // read one slot ahead of the one being processed
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : idx_next;

   sts_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_wa),
      .wr_data (dl_wd),
      .rd_addr (rd_addr),
      .rd_data (dl_rd)
   );

   sts_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_interval_ram (
      .clock   (clock),
      .wr_en   (iv_we),
      .wr_addr (iv_wa),
      .wr_data (iv_wd),
      .rd_addr (rd_addr),
      .rd_data (iv_rd)
   );

   // per-slot decision for the slot whose RAM data is on dl_rd/iv_rd
   always_comb begin
      fin_act = active_ff[idx_ff];
      fin_dl  = dl_rd;
      exp_hit = 1'b0;
      if (active_ff[idx_ff] && !cancel_ff[idx_ff] && (dl_rd <= time_ff)) begin
         exp_hit = 1'b1;
         if (periodic_ff[idx_ff]) begin
            fin_dl = reload;
         end else begin
            fin_act = 1'b0;
         end
      end else if (active_ff[idx_ff] && cancel_ff[idx_ff]) begin
         fin_act = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      soonest_in   = soonest_ff;
      active_in    = active_ff;
      periodic_in  = periodic_ff;
      cancel_in    = cancel_ff;
      ev_in        = ev_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      any_exp_in   = any_exp_ff;
      fold0_in     = fold0_ff;
      folds_in     = folds_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      dl_we        = 1'b0;
      dl_wa        = idx_ff;
      dl_wd        = reload;
      iv_we        = 1'b0;
      iv_wa        = IDX_W'(req_timer_id);
      iv_wd        = TIME_BITS'(req_period);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  MODE_ADVANCE: begin
                     time_in = time_ff + TIME_BITS'(req_amount);
                  end
                  MODE_ARM: begin
                     if (id_ok) begin
                        dl_we      = 1'b1;
                        dl_wa      = IDX_W'(req_timer_id);
                        dl_wd      = time_ff + TIME_BITS'(req_amount);
                        iv_we      = 1'b1;
                        soonest_in = '0;
                        active_in[IDX_W'(req_timer_id)]   = 1'b1;
                        cancel_in[IDX_W'(req_timer_id)]   = 1'b0;
                        periodic_in[IDX_W'(req_timer_id)] = req_repeat;
                     end
                  end
                  MODE_CANCEL: begin
                     if (id_ok) begin
                        cancel_in[IDX_W'(req_timer_id)] = 1'b1;
                     end
                  end
                  MODE_SCAN: begin
                     if (scan_go) begin
                        state_in   = ST_WALK;
                        idx_in     = '0;
                        ev_in      = '0;
                        kind_in    = '0;
                        any_exp_in = 1'b0;
                        fold0_in   = '0;
                        folds_in   = soonest_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_WALK: begin
            if (active_ff[idx_ff] && cancel_ff[idx_ff]) begin
               ev_in   = ev_ff | cur_bit;
               kind_in = kind_ff | cur_bit;
               cancel_in[idx_ff] = 1'b0;
            end else if (exp_hit) begin
               ev_in      = ev_ff | cur_bit;
               any_exp_in = 1'b1;
               dl_we      = periodic_ff[idx_ff];
            end
            active_in[idx_ff] = fin_act;
            // running earliest deadline, from an empty (zero) start and from the cache
            if (fin_act && ((fold0_ff == '0) || (fold0_ff > fin_dl))) begin
               fold0_in = fin_dl;
            end
            if (fin_act && ((folds_ff == '0) || (folds_ff > fin_dl))) begin
               folds_in = fin_dl;
            end
            idx_in = idx_next;
            if (idx_ff == LAST_IDX) begin
               soonest_in = (any_exp_ff || exp_hit) ? fold0_in : folds_in;
               state_in   = (ev_in != '0) ? ST_EMIT : ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (ev_ff[idx_ff]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {(RSP_DATA_W - ID_W - VAL_W)'(0),
                                  VAL_W'(soonest_ff), ID_W'(idx_ff)};
                  rsp_kind_in  = kind_ff[idx_ff];
                  rsp_last_in  = ((ev_ff & ~cur_bit) == '0);
                  ev_in        = ev_ff & ~cur_bit;
                  idx_in       = idx_next;
                  if ((ev_ff & ~cur_bit) == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               idx_in = idx_next;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         soonest_ff   <= '0;
         active_ff    <= '0;
         periodic_ff  <= '0;
         cancel_ff    <= '0;
         ev_ff        <= '0;
         kind_ff      <= '0;
         idx_ff       <= '0;
         any_exp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         soonest_ff   <= soonest_in;
         active_ff    <= active_in;
         periodic_ff  <= periodic_in;
         cancel_ff    <= cancel_in;
         ev_ff        <= ev_in;
         kind_ff      <= kind_in;
         idx_ff       <= idx_in;
         any_exp_ff   <= any_exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fold0_ff    <= fold0_in;
      folds_ff    <= folds_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_kind_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule
